// File: hdl/wsurl_pkg.sv
// shared types, codes and prefix tables for the websocket url splitter
package wsurl_pkg;

  // parse phase codes
  localparam logic [2:0] PhScheme = 3'd0;
  localparam logic [2:0] PhHost   = 3'd1;
  localparam logic [2:0] PhPort   = 3'd2;
  localparam logic [2:0] PhPath   = 3'd3;
  localparam logic [2:0] PhFail   = 3'd4;

  // section tags on each result word
  localparam logic [2:0] SecSep  = 3'd0;
  localparam logic [2:0] SecHost = 3'd1;
  localparam logic [2:0] SecPort = 3'd2;
  localparam logic [2:0] SecPath = 3'd3;
  localparam logic [2:0] SecEnd  = 3'd4;

  // number scanner substates
  localparam logic [1:0] NumSkip = 2'd0;
  localparam logic [1:0] NumDigs = 2'd1;
  localparam logic [1:0] NumStop = 2'd2;

  localparam logic [31:0] PortPlain  = 32'd80;
  localparam logic [31:0] PortSecure = 32'd443;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  scheme_pos;
    logic [1:0]  alive;
    logic [31:0] accum;
    logic [1:0]  num_sub;
    logic        neg;
    logic        port_given;
    logic        secure;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  section;
    logic [7:0]  byte_out;
    logic        done;
    logic        ok;
    logic [31:0] port;
    logic        tls;
  } result_t;

  localparam parse_state_t StateReset = '{
    phase: PhScheme, scheme_pos: 3'd0, alive: 2'b11, accum: 32'd0,
    num_sub: NumSkip, neg: 1'b0, port_given: 1'b0, secure: 1'b0
  };

  // "ws://"
  function automatic logic [7:0] plain_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h77;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h3A;
      3'd3:    ch = 8'h2F;
      3'd4:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "wss://"
  function automatic logic [7:0] secure_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h77;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h73;
      3'd3:    ch = 8'h3A;
      3'd4:    ch = 8'h2F;
      3'd5:    ch = 8'h2F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/wsurl_parse.sv
// next-state and result logic for one url character
module wsurl_parse (
  input  wsurl_pkg::parse_state_t state_i,
  input  logic [7:0]              char_i,
  output wsurl_pkg::parse_state_t state_o,
  output wsurl_pkg::result_t      result_o
);
  import wsurl_pkg::*;

  logic [1:0]  alive;
  logic        blank;
  logic        is_digit;
  logic        is_sign;
  logic [35:0] acc_sum;
  logic [35:0] acc_limit;

  assign blank    = (char_i == 8'h20) || (char_i >= 8'h09 && char_i <= 8'h0D);
  assign is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_sign  = (char_i == 8'h2B) || (char_i == 8'h2D);

  // accum * 10 + digit, kept wide for the saturation compare
  assign acc_sum   = {1'b0, state_i.accum, 3'b000} + {3'b000, state_i.accum, 1'b0}
                   + {32'd0, char_i[3:0] - 4'd0};
  assign acc_limit = state_i.neg ? 36'h080000000 : 36'h07FFFFFFF;

  always_comb begin
    state_o           = state_i;
    alive             = state_i.alive;
    result_o.section  = SecSep;
    result_o.byte_out = char_i;
    result_o.done     = 1'b0;
    result_o.ok       = 1'b0;
    result_o.port     = 32'd0;
    result_o.tls      = 1'b0;

    if (char_i == 8'h00) begin
      result_o.section = SecEnd;
      result_o.done    = 1'b1;
      if (state_i.phase == PhPath) begin
        result_o.ok  = 1'b1;
        result_o.tls = state_i.secure;
        if (state_i.port_given) begin
          result_o.port = state_i.neg ? (32'd0 - state_i.accum) : state_i.accum;
        end else begin
          result_o.port = state_i.secure ? PortSecure : PortPlain;
        end
      end
      state_o = StateReset;
    end else begin
      case (state_i.phase)
        PhScheme: begin
          if (alive[0] && (state_i.scheme_pos >= 3'd5 ||
                           plain_char(state_i.scheme_pos) != char_i)) begin
            alive[0] = 1'b0;
          end
          if (alive[1] && (state_i.scheme_pos >= 3'd6 ||
                           secure_char(state_i.scheme_pos) != char_i)) begin
            alive[1] = 1'b0;
          end
          state_o.alive      = alive;
          state_o.scheme_pos = state_i.scheme_pos + 3'd1;
          if (alive == 2'b00) begin
            state_o.phase = PhFail;
          end else if (alive[0] && state_i.scheme_pos == 3'd4) begin
            state_o.secure = 1'b0;
            state_o.phase  = PhHost;
          end else if (alive[1] && state_i.scheme_pos == 3'd5) begin
            state_o.secure = 1'b1;
            state_o.phase  = PhHost;
          end
        end
        PhHost: begin
          if (char_i == 8'h3A) begin
            state_o.port_given = 1'b1;
            state_o.phase      = PhPort;
          end else if (char_i == 8'h2F) begin
            result_o.section = SecPath;
            state_o.phase    = PhPath;
          end else begin
            result_o.section = SecHost;
          end
        end
        PhPort: begin
          if (char_i == 8'h2F) begin
            result_o.section = SecPath;
            state_o.phase    = PhPath;
          end else begin
            result_o.section = SecPort;
            if (state_i.num_sub == NumSkip && blank) begin
              state_o.num_sub = NumSkip;
            end else if (state_i.num_sub == NumSkip && is_sign) begin
              state_o.neg     = (char_i == 8'h2D);
              state_o.num_sub = NumDigs;
            end else if ((state_i.num_sub == NumSkip || state_i.num_sub == NumDigs)
                         && is_digit) begin
              state_o.accum   = (acc_sum > acc_limit) ? acc_limit[31:0] : acc_sum[31:0];
              state_o.num_sub = NumDigs;
            end else begin
              state_o.num_sub = NumStop;
            end
          end
        end
        PhPath: begin
          result_o.section = SecPath;
        end
        default: begin
          result_o.section = SecSep;
        end
      endcase
    end
  end

endmodule

// File: hdl/websocket_url_splitter_unit.sv
// top level of the websocket url splitter: input register, parse step, result register
//
// Takes a NUL-terminated URL one character word at a time and returns one result
// word per character: the character passed through with its section tag (scheme or
// separator, host, port text, path, end). The terminator word carries the verdict:
// url_done, url_ok, the port (parsed with atoi rules and saturated to 32 bits, or
// 80 / 443 from "ws://" / "wss://") and tls_on; on failure port and tls read 0 and
// host and path words already delivered should be dropped. After the terminator the
// parser returns to its reset state, so URLs may follow one another directly.
// Throughput is one word per clock while out_stall_i stays low: a character is held in
// the input register, passes through the parse step (one 36-bit multiply-by-ten add
// and saturation compare is the longest path) and lands in the result register.
// While a result waits under out_stall_i the input register still takes one more
// word, after which in_stall_o is raised.
module websocket_url_splitter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         section_o,
  output logic [7:0]         byte_out_o,
  output logic               url_done_o,
  output logic               url_ok_o,
  output logic signed [31:0] port_number_o,
  output logic               tls_on_o
);
  import wsurl_pkg::*;

  // input register
  logic         in_valid_q;
  logic [7:0]   char_q;

  // parser context carried from word to word
  parse_state_t state_q;
  parse_state_t state_d;

  // result register
  logic         out_valid_q;
  result_t      result_q;
  result_t      result_d;

  logic         out_free;
  logic         advance;
  logic         in_take;

  // the result register frees up when empty or being taken this edge
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  // input register accepts when empty or moving forward
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  wsurl_parse u_parse (
    .state_i  (state_q),
    .char_i   (char_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign section_o     = result_q.section;
  assign byte_out_o    = result_q.byte_out;
  assign url_done_o    = result_q.done;
  assign url_ok_o      = result_q.ok;
  assign port_number_o = $signed(result_q.port);
  assign tls_on_o      = result_q.tls;

endmodule
